// ===== sv/fwrb_pkg.sv =====
// ============================================================================
// fwrb_pkg
// Shared types and constants for the failure window recovery breaker.
// ============================================================================
`default_nettype none

package fwrb_pkg;

   // request codes carried in req_tuser
   localparam logic [2:0] REQ_SET_READY = 3'd0;
   localparam logic [2:0] REQ_SUCCESS   = 3'd1;
   localparam logic [2:0] REQ_FAILURE   = 3'd2;
   localparam logic [2:0] REQ_PRESENT   = 3'd3;
   localparam logic [2:0] REQ_EVALUATE  = 3'd4;
   localparam logic [2:0] REQ_CONSUME   = 3'd5;

   // csr register indexes
   localparam logic [1:0] CSR_WINDOW_BACK   = 2'd0;
   localparam logic [1:0] CSR_THRESHOLD     = 2'd1;
   localparam logic [1:0] CSR_HOLD_MIN_MS   = 2'd2;
   localparam logic [1:0] CSR_HOLD_MIN_PRES = 2'd3;

   localparam int WFAIL_W = 7;

   // csr reset values
   localparam logic [15:0]        WINDOW_BACK_RST   = 16'd59;
   localparam logic [WFAIL_W-1:0] THRESHOLD_RST     = 7'd3;
   localparam logic [31:0]        HOLD_MIN_MS_RST   = 32'd1000;
   localparam logic [31:0]        HOLD_MIN_PRES_RST = 32'd60;

   typedef enum logic [1:0] {
      MODE_UNINIT = 2'd0,
      MODE_READY  = 2'd1,
      MODE_HOLD   = 2'd2
   } mode_type;

   typedef struct packed {
      logic [15:0]        window_back;
      logic [WFAIL_W-1:0] failure_threshold;
      logic [31:0]        hold_min_ms;
      logic [31:0]        hold_min_presents;
   } cfg_type;

   typedef struct packed {
      logic write;   // record frame in ring
      logic clear;   // drop all ring entries
   } ring_cmd_type;

   typedef struct packed {
      logic [31:0]        hold_count;
      logic [WFAIL_W-1:0] window_failures;
      logic               resume_flag;
      logic               may_evaluate;
      logic [1:0]         mode;
   } result_type;

endpackage

`default_nettype wire

// ===== sv/failure_window_recovery_breaker.sv =====
// ============================================================================
// failure_window_recovery_breaker
// Failure-rate breaker with a sliding frame window and timed recovery.
// ============================================================================
// Usage:
//  - req channel: one request per handshake; req_tuser holds the request code
//    (set_ready, success, failure, present, evaluate, consume_resume),
//    req_tdata the frame number and millisecond time.
//  - rsp channel: exactly one response per request, in request order, with
//    mode after the request, evaluate/consume answers, window failure count
//    and the wrapping hold entry count.
//  - csr channel: writes window_back, failure_threshold, hold_min_ms and
//    hold_min_presents; always ready. Write only while no request is in flight.
//  - Path: a request accepted on req passes the input register, then the
//    response register, before it can be taken on rsp. Throughput: one
//    request per cycle while rsp_tready stays high; all per-request work is
//    one pass from the input register through the window compare over the
//    failure ring and the mode update.
//  - Back-pressure: while rsp_tready is low the response register holds, the
//    input register fills, and req_tready drops until the response is taken.
//  - Reset (synchronous, active high): mode uninitialized, ring empty,
//    counters zero, csr registers back to their defaults, both channels empty.
// ============================================================================
`default_nettype none

module failure_window_recovery_breaker
   import fwrb_pkg::*;
#(
   parameter int FAILURE_SLOTS = 8
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // request channel
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [127:0] req_tdata,   // [63:0] frame_id, [127:64] now_ms
   input  wire logic [2:0]   req_tuser,   // [2:0] req_type
   // response channel
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [47:0]       rsp_tdata,   // [1:0] mode, [2] may_evaluate,
                                          // [3] resume_flag, [10:4] window_failures,
                                          // [42:11] hold_count, [47:43] zero
   // csr write channel
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [31:0]  csr_wdata
);

   // input register
   logic         in_valid_ff;
   logic [2:0]   in_type_ff;
   logic [63:0]  in_frame_ff;
   logic [63:0]  in_now_ff;
   // response register
   logic         rsp_valid_ff;
   result_type   rsp_data_ff;

   cfg_type      cfg_ff;
   ring_cmd_type ring_cmd;
   result_type   result;
   logic [WFAIL_W-1:0] wcount;
   logic         step;
   logic         req_fire;

   // request moves to the response register when that register is free
   assign step       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_type_ff  <= req_tuser;
         in_frame_ff <= req_tdata[63:0];
         in_now_ff   <= req_tdata[127:64];
      end
   end

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_back       <= WINDOW_BACK_RST;
         cfg_ff.failure_threshold <= THRESHOLD_RST;
         cfg_ff.hold_min_ms       <= HOLD_MIN_MS_RST;
         cfg_ff.hold_min_presents <= HOLD_MIN_PRES_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_WINDOW_BACK:   cfg_ff.window_back       <= csr_wdata[15:0];
            CSR_THRESHOLD:     cfg_ff.failure_threshold <= csr_wdata[WFAIL_W-1:0];
            CSR_HOLD_MIN_MS:   cfg_ff.hold_min_ms       <= csr_wdata;
            CSR_HOLD_MIN_PRES: cfg_ff.hold_min_presents <= csr_wdata;
            default: ;
         endcase
      end
   end

   fwrb_window #(
      .FAILURE_SLOTS (FAILURE_SLOTS)
   ) u_window (
      .clock       (clock),
      .reset       (reset),
      .cmd         (ring_cmd),
      .frame_id    (in_frame_ff),
      .window_back (cfg_ff.window_back),
      .count       (wcount)
   );

   fwrb_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .req_type (in_type_ff),
      .now_ms   (in_now_ff),
      .cfg      (cfg_ff),
      .wcount   (wcount),
      .ring_cmd (ring_cmd),
      .result   (result)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_data_ff.hold_count, rsp_data_ff.window_failures,
                        rsp_data_ff.resume_flag, rsp_data_ff.may_evaluate,
                        rsp_data_ff.mode};

endmodule

`default_nettype wire

// ===== sv/fwrb_window.sv =====
// ============================================================================
// fwrb_window
// Ring of recent failure frames and the in-window failure count.
// ============================================================================
`default_nettype none

module fwrb_window
   import fwrb_pkg::*;
#(
   parameter int FAILURE_SLOTS = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ring_cmd_type       cmd,
   input  wire logic [63:0]        frame_id,
   input  wire logic [15:0]        window_back,
   output logic      [WFAIL_W-1:0] count
);

   localparam int SlotW = (FAILURE_SLOTS > 1) ? $clog2(FAILURE_SLOTS) : 1;
   localparam int CntW  = $clog2(FAILURE_SLOTS + 1);

   logic [63:0]              frames_ff [FAILURE_SLOTS];
   logic [FAILURE_SLOTS-1:0] valid_ff;
   logic [FAILURE_SLOTS-1:0] valid_in;
   logic [SlotW-1:0]         slot_ff;
   logic [SlotW-1:0]         slot_in;
   logic [63:0]              first;
   logic [FAILURE_SLOTS-1:0] hit;
   logic [CntW-1:0]          cnt;

   // window start clamps at frame zero
   assign first = (frame_id >= {48'd0, window_back}) ?
                  (frame_id - {48'd0, window_back}) : 64'd0;

   // the slot about to be overwritten is replaced by the new frame,
   // which always lies in its own window
   always_comb begin
      for (int i = 0; i < FAILURE_SLOTS; i++) begin
         hit[i] = valid_ff[i] && (slot_ff != SlotW'(i)) &&
                  (frames_ff[i] >= first) && (frames_ff[i] <= frame_id);
      end
      cnt = CntW'(1);
      for (int i = 0; i < FAILURE_SLOTS; i++) begin
         cnt = cnt + CntW'(hit[i]);
      end
   end

   assign count = WFAIL_W'(cnt);

   always_comb begin
      valid_in = valid_ff;
      slot_in  = slot_ff;
      if (cmd.clear) begin
         valid_in = '0;
         slot_in  = '0;
      end else if (cmd.write) begin
         valid_in[slot_ff] = 1'b1;
         slot_in = (slot_ff == SlotW'(FAILURE_SLOTS - 1)) ? '0 : slot_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         slot_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         slot_ff  <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write && !cmd.clear) begin
         frames_ff[slot_ff] <= frame_id;
      end
   end

endmodule

`default_nettype wire

// ===== sv/fwrb_ctrl.sv =====
// ============================================================================
// fwrb_ctrl
// Mode state, hold bookkeeping and result formation for one request.
// ============================================================================
`default_nettype none

module fwrb_ctrl
   import fwrb_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire logic [2:0]         req_type,
   input  wire logic [63:0]        now_ms,
   input  wire cfg_type            cfg,
   input  wire logic [WFAIL_W-1:0] wcount,
   output ring_cmd_type            ring_cmd,
   output result_type              result
);

   mode_type    mode_ff, mode_in;
   logic [63:0] hold_start_ff, hold_start_in;
   logic [31:0] present_ff, present_in;
   logic        resume_ff, resume_in;
   logic [31:0] hold_total_ff, hold_total_in;
   logic [63:0] elapsed;
   logic        may_eval;
   logic        resume_out;
   logic [WFAIL_W-1:0] wfail;

   assign elapsed = now_ms - hold_start_ff;

   always_comb begin
      mode_in       = mode_ff;
      hold_start_in = hold_start_ff;
      present_in    = present_ff;
      resume_in     = resume_ff;
      hold_total_in = hold_total_ff;
      ring_cmd      = '0;
      may_eval      = 1'b0;
      resume_out    = 1'b0;
      wfail         = '0;
      if (step) begin
         case (req_type)
            REQ_SET_READY: begin
               ring_cmd.clear = 1'b1;
               mode_in        = MODE_READY;
               present_in     = '0;
               resume_in      = 1'b0;
            end
            REQ_SUCCESS: begin
               if (mode_ff == MODE_UNINIT) mode_in = MODE_READY;
            end
            REQ_FAILURE: begin
               if (mode_ff != MODE_HOLD) begin
                  ring_cmd.write = 1'b1;
                  wfail = wcount;
                  if (wcount >= cfg.failure_threshold) begin
                     mode_in       = MODE_HOLD;
                     hold_start_in = now_ms;
                     present_in    = '0;
                     hold_total_in = hold_total_ff + 32'd1;
                  end
               end
            end
            REQ_PRESENT: begin
               if (mode_ff == MODE_HOLD && present_ff != '1)
                  present_in = present_ff + 32'd1;
            end
            REQ_EVALUATE: begin
               if (mode_ff != MODE_HOLD) begin
                  may_eval = 1'b1;
               end else if (elapsed >= {32'd0, cfg.hold_min_ms} &&
                            present_ff >= cfg.hold_min_presents) begin
                  ring_cmd.clear = 1'b1;
                  mode_in        = MODE_READY;
                  resume_in      = 1'b1;
                  present_in     = '0;
                  may_eval       = 1'b1;
               end
            end
            REQ_CONSUME: begin
               resume_out = resume_ff;
               resume_in  = 1'b0;
            end
            default: ;
         endcase
      end
   end

   assign result.mode            = mode_in;
   assign result.may_evaluate    = may_eval;
   assign result.resume_flag     = resume_out;
   assign result.window_failures = wfail;
   assign result.hold_count      = hold_total_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_UNINIT;
         hold_start_ff <= '0;
         present_ff    <= '0;
         resume_ff     <= 1'b0;
         hold_total_ff <= '0;
      end else begin
         mode_ff       <= mode_in;
         hold_start_ff <= hold_start_in;
         present_ff    <= present_in;
         resume_ff     <= resume_in;
         hold_total_ff <= hold_total_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/fwrb_checker.sv =====
// ============================================================================
// fwrb_checker
// Port-level checks for the failure window recovery breaker.
// ============================================================================
`default_nettype none

module fwrb_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata
);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // reset empties the response register
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // with no response pending the input side never stalls
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty response register");

   // evaluate answers never share a response with consume or failure answers
   a_one_answer: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[2] && rsp_tdata[3]) &&
                     !(rsp_tdata[2] && rsp_tdata[10:4] != 7'd0))
      else $error("more than one answer in one response");

   // a granted evaluate never leaves the block in hold
   a_eval_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> rsp_tdata[1:0] != 2'd2)
      else $error("evaluate granted while in hold");

endmodule

bind failure_window_recovery_breaker fwrb_checker u_fwrb_checker (.*);

`default_nettype wire

// ===== tb/sv/failure_window_recovery_breaker_checker.sv =====
// ----------------------------------------------------------------------------
// failure_window_recovery_breaker_checker
// Watches the request, response and csr channels of the breaker, keeps its
// own copy of the breaker state, predicts one response per request and
// compares every response with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module failure_window_recovery_breaker_checker
   import fwrb_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [127:0] req_tdata,
   input  wire logic [2:0]   req_tuser,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [47:0]  rsp_tdata,
   input  wire logic         csr_valid,
   input  wire logic         csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [31:0]  csr_wdata,
   output int                mismatch_count,
   output int                responses_due
);

   localparam int SLOTS = 8;

   cfg_type           cfg;
   logic [63:0]       ring_frame [SLOTS];
   logic [SLOTS-1:0]  ring_valid;
   int                ring_next;
   mode_type          mode_now;
   logic [63:0]       hold_since;
   logic [31:0]       present_total;
   logic              resume_armed;
   logic [31:0]       hold_entries;
   result_type        breaker_answers [$];

   // one breaker request applied to the shadow state
   function automatic result_type breaker_step(input logic [2:0] kind,
                                               input logic [63:0] frame,
                                               input logic [63:0] now);
      result_type  r;
      logic [63:0] first;
      int          hits;
      r = '0;
      hits = 0;
      case (kind)
         REQ_SET_READY: begin
            ring_valid = '0;
            ring_next = 0;
            mode_now = MODE_READY;
            present_total = '0;
            resume_armed = 1'b0;
         end
         REQ_SUCCESS: begin
            if (mode_now == MODE_UNINIT) mode_now = MODE_READY;
         end
         REQ_FAILURE: begin
            if (mode_now != MODE_HOLD) begin
               ring_frame[ring_next] = frame;
               ring_valid[ring_next] = 1'b1;
               ring_next = (ring_next + 1) % SLOTS;
               // window clips at frame zero
               first = (frame >= {48'd0, cfg.window_back}) ?
                       frame - {48'd0, cfg.window_back} : 64'd0;
               for (int i = 0; i < SLOTS; i++)
                  if (ring_valid[i] && ring_frame[i] >= first && ring_frame[i] <= frame)
                     hits++;
               r.window_failures = hits[WFAIL_W-1:0];
               if (hits >= int'(cfg.failure_threshold)) begin
                  mode_now = MODE_HOLD;
                  hold_since = now;
                  present_total = '0;
                  hold_entries = hold_entries + 32'd1;
               end
            end
         end
         REQ_PRESENT: begin
            if (mode_now == MODE_HOLD && present_total != '1)
               present_total = present_total + 32'd1;
         end
         REQ_EVALUATE: begin
            if (mode_now != MODE_HOLD) begin
               r.may_evaluate = 1'b1;
            end else if (now - hold_since >= {32'd0, cfg.hold_min_ms} &&
                         present_total >= cfg.hold_min_presents) begin
               ring_valid = '0;
               ring_next = 0;
               mode_now = MODE_READY;
               resume_armed = 1'b1;
               present_total = '0;
               r.may_evaluate = 1'b1;
            end
         end
         REQ_CONSUME: begin
            r.resume_flag = resume_armed;
            resume_armed = 1'b0;
         end
         default: ;
      endcase
      r.mode = mode_now;
      r.hold_count = hold_entries;
      return r;
   endfunction

   task automatic note_field(input string name, input longint unsigned want,
                             input longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         cfg = '{WINDOW_BACK_RST, THRESHOLD_RST, HOLD_MIN_MS_RST, HOLD_MIN_PRES_RST};
         ring_valid = '0;
         ring_next = 0;
         mode_now = MODE_UNINIT;
         hold_since = '0;
         present_total = '0;
         resume_armed = 1'b0;
         hold_entries = '0;
         breaker_answers.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WINDOW_BACK:   cfg.window_back = csr_wdata[15:0];
               CSR_THRESHOLD:     cfg.failure_threshold = csr_wdata[WFAIL_W-1:0];
               CSR_HOLD_MIN_MS:   cfg.hold_min_ms = csr_wdata;
               CSR_HOLD_MIN_PRES: cfg.hold_min_presents = csr_wdata;
               default: ;
            endcase
         end
         // retire before predicting so a response never meets its own request
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[42:0]);
            if (breaker_answers.size() == 0) begin
               $error("unexpected response: rsp_tdata 0x%h", rsp_tdata);
               mismatch_count++;
            end else begin
               want = breaker_answers.pop_front();
               note_field("mode", want.mode, got.mode);
               note_field("may_evaluate", want.may_evaluate, got.may_evaluate);
               note_field("resume_flag", want.resume_flag, got.resume_flag);
               note_field("window_failures", want.window_failures, got.window_failures);
               note_field("hold_count", want.hold_count, got.hold_count);
            end
         end
         if (req_tvalid && req_tready)
            breaker_answers.push_back(breaker_step(req_tuser, req_tdata[63:0],
                                                   req_tdata[127:64]));
      end
      responses_due = breaker_answers.size();
   end

endmodule

// ===== tb/sv/failure_window_recovery_breaker_test.sv =====
// ----------------------------------------------------------------------------
// failure_window_recovery_breaker_test
// Stimulus and verdict for the failure window breaker: a directed sequence
// under reset settings, then random request streams under several csr
// settings, with bursty requests and a patterned response stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module failure_window_recovery_breaker_test;
   import fwrb_pkg::*;

   // request codes the block ignores
   localparam logic [2:0] REQ_SPARE_A = 3'd6;
   localparam logic [2:0] REQ_SPARE_B = 3'd7;

   localparam int NUM_PHASES = 7;
   localparam int PHASE_REQS = 130;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [127:0] req_tdata = '0;   // [63:0] frame_id, [127:64] now_ms
   logic [2:0]   req_tuser = '0;   // [2:0] req_type
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [47:0]  rsp_tdata;        // [1:0] mode, [2] may_evaluate, [3] resume_flag,
                                   // [10:4] window_failures, [42:11] hold_count
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic [1:0]   csr_index = '0;
   logic [31:0]  csr_wdata = '0;

   int           mismatch_count;
   int           responses_due;
   int           sent_count = 0;
   bit           stuck = 1'b0;

   // walking frame and time counters for well-formed failure streams
   logic [63:0]  cur_frame = '0;
   logic [63:0]  cur_ms = '0;
   cfg_type      active;
   cfg_type      plan [NUM_PHASES];

   logic [31:0]  stall_tick = '0;
   logic [1:0]   stall_mode = '0;

   always #5 clock = ~clock;

   failure_window_recovery_breaker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   failure_window_recovery_breaker_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .responses_due  (responses_due)
   );

   // Response side stall: whenever stall_tick[5:0] wraps to zero, pick a new pattern -
   // always ready, coin flip, mostly stalled, or ready while stall_tick[2:0] < 5.
   always @(posedge clock) begin
      stall_tick <= stall_tick + 32'd1;
      if (stall_tick[5:0] == 6'd0) stall_mode <= 2'($urandom_range(0, 3));
      case (stall_mode)
         2'd0:    rsp_tready <= 1'b1;
         2'd1:    rsp_tready <= 1'($urandom_range(0, 1));
         2'd2:    rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= (stall_tick[2:0] < 3'd5);
      endcase
   end

   // One request; valid stays up after the handshake so back-to-back
   // requests never drop it within a step.
   task automatic send_req(input logic [2:0] kind, input logic [63:0] frame,
                           input logic [63:0] now);
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {now, frame};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
   endtask

   task automatic idle_cycles(input int n);
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Drop valid and hold off until every predicted response has come back,
   // then let the two-stage pipeline empty.
   task automatic wait_for_idle();
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (responses_due != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      if (responses_due != 0) stuck = 1'b1;
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_put(input logic [1:0] index, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // all four registers, valid dropped only after the last write
   task automatic write_settings(input cfg_type s);
      csr_put(CSR_WINDOW_BACK, {16'd0, s.window_back});
      csr_put(CSR_THRESHOLD, {25'd0, s.failure_threshold});
      csr_put(CSR_HOLD_MIN_MS, s.hold_min_ms);
      csr_put(CSR_HOLD_MIN_PRES, s.hold_min_presents);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Random stream. Failures walk forward in frame number so they cluster
   // in the window and trip hold; time walks forward in steps scaled to
   // hold_min_ms so recovery lands near its boundary. A few full-width
   // jumps, near-max frames and stale frames stir the window arithmetic.
   task automatic run_random(input int count);
      int          burst;
      int          pick;
      logic [2:0]  kind;
      logic [63:0] frame;
      logic [63:0] now;
      burst = $urandom_range(1, 16);
      for (int i = 0; i < count; i++) begin
         // mid-phase pause until the response queue runs dry
         if (i == count / 2) wait_for_idle();
         pick = $urandom_range(0, 99);
         if (pick < 4)       kind = REQ_SET_READY;
         else if (pick < 9)  kind = REQ_SUCCESS;
         else if (pick < 40) kind = REQ_FAILURE;
         else if (pick < 68) kind = REQ_PRESENT;
         else if (pick < 84) kind = REQ_EVALUATE;
         else if (pick < 95) kind = REQ_CONSUME;
         else if (pick < 97) kind = REQ_SPARE_A;
         else                kind = REQ_SPARE_B;
         // don't-care fields still toggle every bit
         frame = {$urandom(), $urandom()};
         now = {$urandom(), $urandom()};
         if (kind == REQ_FAILURE) begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
               cur_frame = {$urandom(), $urandom()};
            else if (pick < 8)
               cur_frame = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(0, 3);
            else if (pick < 11)
               cur_frame = $urandom_range(0, active.window_back);   // at or below window_back
            else
               cur_frame = cur_frame + $urandom_range(0, active.window_back / 3 + 1);
            frame = cur_frame;
            if (pick >= 11 && pick < 16)   // stale frame, may fall outside the window
               frame = cur_frame - $urandom_range(0, active.window_back + 1);
         end
         if (kind == REQ_FAILURE || kind == REQ_EVALUATE) begin
            if ($urandom_range(0, 99) < 5)
               cur_ms = {$urandom(), $urandom()};   // elapsed time may wrap
            else
               cur_ms = cur_ms + $urandom_range(0, active.hold_min_ms / 4 + 2);
            now = cur_ms;
         end
         send_req(kind, frame, now);
         burst--;
         if (burst == 0) begin
            if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 6));
            burst = $urandom_range(1, 16);
         end
      end
   endtask

   initial begin
      plan[0] = '{16'd5, 7'd2, 32'd100, 32'd3};
      plan[1] = '{16'd0, 7'd1, 32'd0, 32'd0};                    // low extremes
      plan[2] = '{16'hFFFF, 7'd64, 32'hFFFF_FFFF, 32'hFFFF_FFFF}; // high extremes
      plan[3] = '{16'd59, 7'd0, 32'd50, 32'd5};                  // threshold zero
      plan[5] = '{16'd16, 7'd8, 32'd20, 32'd1};                  // threshold = ring size
      plan[6] = '{WINDOW_BACK_RST, THRESHOLD_RST, HOLD_MIN_MS_RST, HOLD_MIN_PRES_RST};

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed pass under reset settings (window 59, threshold 3).
      send_req(REQ_EVALUATE, 64'd0, 64'd0);          // evaluate while uninitialized
      send_req(REQ_CONSUME, 64'd0, 64'd0);           // nothing to consume
      send_req(REQ_PRESENT, 64'd0, 64'd0);           // present outside hold
      send_req(REQ_SUCCESS, 64'd0, 64'd0);           // uninitialized -> ready
      send_req(REQ_SUCCESS, '1, '1);                 // ready stays ready
      send_req(REQ_SPARE_A, '1, '1);
      send_req(REQ_SPARE_B, 64'd0, 64'd0);
      send_req(REQ_FAILURE, 64'd0, 64'd0);           // frame below window_back
      send_req(REQ_FAILURE, '1, '1);                 // largest frame, frame 0 drops out
      send_req(REQ_FAILURE, 64'd2, 64'd10);
      send_req(REQ_FAILURE, 64'd30, 64'd100);        // third in window -> hold
      send_req(REQ_FAILURE, 64'd31, 64'd200);        // ignored in hold
      send_req(REQ_PRESENT, '1, '1);
      send_req(REQ_EVALUATE, '1, 64'd1099);          // one ms short
      send_req(REQ_EVALUATE, 64'd0, 64'd1100);       // time met, presents short
      send_req(REQ_EVALUATE, 64'd0, 64'd5);          // elapsed wraps below hold start
      send_req(REQ_CONSUME, '1, '1);
      send_req(REQ_SET_READY, '1, '1);               // forced out of hold
      send_req(REQ_FAILURE, 64'd100, 64'd300);       // ring was cleared
      send_req(REQ_CONSUME, 64'd0, 64'd0);
      wait_for_idle();

      cur_frame = 64'd1000;
      cur_ms = 64'd5000;
      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p == 4)
            plan[4] = '{16'($urandom_range(0, 300)), 7'($urandom_range(1, 8)),
                        32'($urandom_range(0, 500)), 32'($urandom_range(0, 10))};
         active = plan[p];
         write_settings(active);
         // start each phase from ready so failures can count
         send_req(REQ_SET_READY, 64'd0, 64'd0);
         run_random(PHASE_REQS);
         wait_for_idle();
      end

      repeat (10) @(posedge clock);
      $display("Run covered %0d requests: a directed pass at reset settings, then %0d csr",
               sent_count, NUM_PHASES);
      $display("settings incl. threshold zero and full-width limits, both sides idling.");
      if (mismatch_count == 0 && !stuck && responses_due == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #5000000;
      $display("Some tests failed");
      $finish;
   end

endmodule
